>>> rtl/rqks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rqks_pkg;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = 7;

    localparam logic [2:0] CMD_PUSH      = 3'd0;
    localparam logic [2:0] CMD_POP       = 3'd1;
    localparam logic [2:0] CMD_SORT_CPU  = 3'd2;
    localparam logic [2:0] CMD_SORT_PRIO = 3'd3;
    localparam logic [2:0] CMD_SORT_IO   = 3'd4;
    localparam logic [2:0] CMD_QUERY     = 3'd5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  proc_id;
        logic [15:0] cpu_burst;
        logic [15:0] io_burst;
        logic [7:0]  prio_level;
    } t_rec;

    typedef struct packed {
        logic [1:0]    status;
        logic          item_valid;
        t_rec          rec;
        logic [CW-1:0] entry_count;
        logic          is_full;
        logic          is_empty;
        logic [7:0]    front_id;
        logic [7:0]    rear_id;
    } t_rsp;

    typedef struct packed {
        logic latch;
        logic push_wr;
        logic rej_full;
        logic rej_empty;
        logic pop_rd;
        logic pop_take;
        logic sort_init;
        logic sort_start;
        logic sort_load;
        logic sort_step;
        logic sort_end;
        logic front_rd;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic is_sort;
        logic full;
        logic empty;
        logic few;
        logic k_last;
        logic pass_last;
    } t_dp_sts;

    function automatic logic [CW-1:0] f_eff_cap(input logic [CW-1:0] v);
        logic [CW-1:0] c;
        c = v;
        if (v == '0) begin
            c = CW'(1);
        end else if (v > CW'(DEPTH)) begin
            c = CW'(DEPTH);
        end
        return c;
    endfunction

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] idx,
                                             input logic [CW-1:0] cap);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc >= cap) ? '0 : AW'(inc);
    endfunction

    function automatic logic [15:0] f_key(input t_rec r, input logic [2:0] cmd);
        logic [15:0] k;
        case (cmd)
            CMD_SORT_CPU:  k = r.cpu_burst;
            CMD_SORT_PRIO: k = {8'd0, r.prio_level};
            default:       k = r.io_burst;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rqks_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rqks_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  in_proc_id;
    logic [15:0] in_cpu_burst;
    logic [15:0] in_io_burst;
    logic [7:0]  in_prio_level;

    modport source (output valid, command, in_proc_id, in_cpu_burst, in_io_burst,
                    in_prio_level, input ready);
    modport sink (input valid, command, in_proc_id, in_cpu_burst, in_io_burst,
                  in_prio_level, output ready);
endinterface

interface rqks_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        item_valid;
    logic [7:0]  out_proc_id;
    logic [15:0] out_cpu_burst;
    logic [15:0] out_io_burst;
    logic [7:0]  out_prio_level;
    logic [6:0]  entry_count;
    logic        is_full;
    logic        is_empty;
    logic [7:0]  front_id;
    logic [7:0]  rear_id;

    modport source (output valid, status, item_valid, out_proc_id, out_cpu_burst,
                    out_io_burst, out_prio_level, entry_count, is_full, is_empty,
                    front_id, rear_id, input ready);
    modport sink (input valid, status, item_valid, out_proc_id, out_cpu_burst,
                  out_io_burst, out_prio_level, entry_count, is_full, is_empty,
                  front_id, rear_id, output ready);
endinterface

`default_nettype wire

>>> rtl/rqks_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rqks_ram #(
    parameter int unsigned W = 48,
    parameter int unsigned D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re_a,
    input  logic [$clog2(D)-1:0] i_raddr_a,
    output logic [W-1:0]         o_rdata_a,
    input  logic                 i_re_b,
    input  logic [$clog2(D)-1:0] i_raddr_b,
    output logic [W-1:0]         o_rdata_b
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rda;
    logic [W-1:0] r_rdb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rda <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdb <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rda;
    assign o_rdata_b = r_rdb;

endmodule

`default_nettype wire

>>> rtl/rqks_ctl.sv
`timescale 1ns / 1ps
`default_nettype none

module rqks_ctl import rqks_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POPW,
        S_PSTART,
        S_LOAD,
        S_STEP,
        S_PEND,
        S_FRD,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_vld;
    t_dp_cmd w_ctl;

    always_comb begin
        w_ctl   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FRD;
                if (i_sts.is_push) begin
                    if (i_sts.full) begin
                        w_ctl.rej_full = 1'b1;
                    end else begin
                        w_ctl.push_wr = 1'b1;
                    end
                end else if (i_sts.is_pop) begin
                    if (i_sts.empty) begin
                        w_ctl.rej_empty = 1'b1;
                    end else begin
                        w_ctl.pop_rd = 1'b1;
                        n_state      = S_POPW;
                    end
                end else if (i_sts.is_sort && !i_sts.few) begin
                    w_ctl.sort_init = 1'b1;
                    n_state         = S_PSTART;
                end
            end
            S_POPW: begin
                w_ctl.pop_take = 1'b1;
                n_state        = S_FRD;
            end
            S_PSTART: begin
                w_ctl.sort_start = 1'b1;
                n_state          = S_LOAD;
            end
            S_LOAD: begin
                w_ctl.sort_load = 1'b1;
                n_state         = S_STEP;
            end
            S_STEP: begin
                w_ctl.sort_step = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_PEND;
                end
            end
            S_PEND: begin
                w_ctl.sort_end = 1'b1;
                n_state        = i_sts.pass_last ? S_FRD : S_PSTART;
            end
            S_FRD: begin
                w_ctl.front_rd = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    w_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_ctl       = w_ctl;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

>>> rtl/rqks_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rqks_dp import rqks_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_wdata,
    input  logic [2:0]    i_command,
    input  t_rec          i_rec,
    input  t_dp_cmd       i_ctl,
    output t_dp_sts       o_sts,
    output t_rsp          o_rsp
);

    logic [2:0]    r_cmd;
    t_rec          r_rec;
    logic [CW-1:0] r_cap;
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    t_status       r_st;
    logic          r_pop_vld;
    t_rec          r_pop;
    t_rec          r_hold;
    logic [AW-1:0] r_sp;
    logic [AW-1:0] r_ra;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_pl;
    t_rsp          r_rsp;

    t_rec          w_rda;
    t_rec          w_rdb;
    logic          w_gt;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_rec          w_wdata;
    logic          w_re_a;
    logic [AW-1:0] w_raddr_a;
    logic [AW-1:0] w_rear;

    assign w_gt = f_key(r_hold, r_cmd) > f_key(w_rda, r_cmd);

    assign w_we    = i_ctl.push_wr | i_ctl.sort_step | i_ctl.sort_end;
    assign w_waddr = i_ctl.push_wr ? r_wr : r_sp;
    assign w_wdata = i_ctl.push_wr ? r_rec :
                     (i_ctl.sort_step && w_gt) ? w_rda : r_hold;

    assign w_re_a    = i_ctl.pop_rd | i_ctl.sort_start | i_ctl.sort_load |
                       i_ctl.sort_step | i_ctl.front_rd;
    assign w_raddr_a = (i_ctl.sort_load || i_ctl.sort_step) ? r_ra : r_rd;
    assign w_rear    = (r_wr == '0) ? AW'(r_cap - CW'(1)) : r_wr - AW'(1);

    rqks_ram #(
        .W ($bits(t_rec)),
        .D (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re_a    (w_re_a),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rda),
        .i_re_b    (i_ctl.front_rd),
        .i_raddr_b (w_rear),
        .o_rdata_b (w_rdb)
    );

    // ring pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CW'(DEPTH);
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else if (i_cfg_we) begin
            r_cap <= f_eff_cap(i_cfg_wdata);
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctl.push_wr) begin
                r_wr  <= f_next(r_wr, r_cap);
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_ctl.pop_take) begin
                r_rd  <= f_next(r_rd, r_cap);
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd     <= i_command;
            r_rec     <= i_rec;
            r_st      <= ST_OK;
            r_pop_vld <= 1'b0;
            r_pop     <= '0;
        end
        if (i_ctl.rej_full) begin
            r_st <= ST_FULL;
        end
        if (i_ctl.rej_empty) begin
            r_st <= ST_EMPTY;
        end
        if (i_ctl.pop_take) begin
            r_pop     <= w_rda;
            r_pop_vld <= 1'b1;
        end
        if (i_ctl.sort_init) begin
            r_pl <= r_cnt - CW'(1);
        end
        // one bubble pass: the larger record rides in r_hold
        if (i_ctl.sort_start) begin
            r_sp <= r_rd;
            r_ra <= f_next(r_rd, r_cap);
            r_k  <= CW'(1);
        end
        if (i_ctl.sort_load) begin
            r_hold <= w_rda;
            r_ra   <= f_next(r_ra, r_cap);
        end
        if (i_ctl.sort_step) begin
            if (!w_gt) begin
                r_hold <= w_rda;
            end
            r_sp <= f_next(r_sp, r_cap);
            r_ra <= f_next(r_ra, r_cap);
            r_k  <= r_k + CW'(1);
        end
        if (i_ctl.sort_end) begin
            r_pl <= r_pl - CW'(1);
        end
        if (i_ctl.load_out) begin
            r_rsp.status      <= r_st;
            r_rsp.item_valid  <= r_pop_vld;
            r_rsp.rec         <= r_pop;
            r_rsp.entry_count <= r_cnt;
            r_rsp.is_full     <= (r_cnt == r_cap);
            r_rsp.is_empty    <= (r_cnt == '0);
            r_rsp.front_id    <= (r_cnt != '0) ? w_rda.proc_id : 8'd0;
            r_rsp.rear_id     <= (r_cnt != '0) ? w_rdb.proc_id : 8'd0;
        end
    end

    assign o_sts.is_push   = (r_cmd == CMD_PUSH);
    assign o_sts.is_pop    = (r_cmd == CMD_POP);
    assign o_sts.is_sort   = (r_cmd == CMD_SORT_CPU) || (r_cmd == CMD_SORT_PRIO) ||
                             (r_cmd == CMD_SORT_IO);
    assign o_sts.full      = (r_cnt >= r_cap);
    assign o_sts.empty     = (r_cnt == '0);
    assign o_sts.few       = (r_cnt < CW'(2));
    assign o_sts.k_last    = (r_k == r_cnt - CW'(1));
    assign o_sts.pass_last = (r_pl == CW'(1));

    assign o_rsp = r_rsp;

`ifndef SYNTH
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_cap)
        else $error("fill level above capacity");

    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push_wr && !i_cfg_we) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("push did not raise fill level");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty ring with split pointers");
`endif

endmodule

`default_nettype wire

>>> rtl/ring_queue_with_key_sort.sv
// Each command passes through accept, execute, front/rear read and output load; a pop
// adds a take step and a sort of two or more records adds its bubble passes.
// No new command is accepted until the result word is loaded, and the load waits
// while an earlier result word is still held unaccepted at the output.
// Reset (synchronous, active low): queue emptied, capacity 64; record store not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ring_queue_with_key_sort import rqks_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rqks_req_if.sink      i_req,
    rqks_rsp_if.source    o_rsp,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_wdata
);

    t_dp_cmd w_ctl;
    t_dp_sts w_sts;
    t_rsp    w_rsp;
    t_rec    w_rec;

    assign w_rec.proc_id    = i_req.in_proc_id;
    assign w_rec.cpu_burst  = i_req.in_cpu_burst;
    assign w_rec.io_burst   = i_req.in_io_burst;
    assign w_rec.prio_level = i_req.in_prio_level;

    rqks_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    rqks_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_command   (i_req.command),
        .i_rec       (w_rec),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .o_rsp       (w_rsp)
    );

    assign o_rsp.status         = w_rsp.status;
    assign o_rsp.item_valid     = w_rsp.item_valid;
    assign o_rsp.out_proc_id    = w_rsp.rec.proc_id;
    assign o_rsp.out_cpu_burst  = w_rsp.rec.cpu_burst;
    assign o_rsp.out_io_burst   = w_rsp.rec.io_burst;
    assign o_rsp.out_prio_level = w_rsp.rec.prio_level;
    assign o_rsp.entry_count    = w_rsp.entry_count;
    assign o_rsp.is_full        = w_rsp.is_full;
    assign o_rsp.is_empty       = w_rsp.is_empty;
    assign o_rsp.front_id       = w_rsp.front_id;
    assign o_rsp.rear_id        = w_rsp.rear_id;

endmodule

`default_nettype wire

>>> sim/ring_queue_with_key_sort_tracker.sv
`timescale 1ns / 1ps

module ring_queue_with_key_sort_tracker import rqks_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rqks_req_if           i_req,
    rqks_rsp_if           i_rsp,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_wdata,
    output int            o_fail_count,
    output int            o_pending
);

    t_rec          slot_mem [DEPTH];
    int            wr_ptr;
    int            rd_ptr;
    int            live_cnt;
    logic [CW-1:0] cap_reg;
    t_rsp          expected_words [$];
    bit            word_bad;

    function automatic int usable_slots();
        if (cap_reg == '0) begin
            return 1;
        end
        if (cap_reg > CW'(DEPTH)) begin
            return DEPTH;
        end
        return int'(cap_reg);
    endfunction

    function automatic int ring_next(input int idx, input int lim);
        return (idx + 1 < lim) ? idx + 1 : 0;
    endfunction

    function automatic logic [15:0] sort_key(input t_rec r, input logic [2:0] cmd);
        if (cmd == CMD_SORT_CPU) begin
            return r.cpu_burst;
        end
        if (cmd == CMD_SORT_PRIO) begin
            return {8'd0, r.prio_level};
        end
        return r.io_burst;
    endfunction

    // stable insertion sort over the live part of the ring
    function automatic void sort_live(input logic [2:0] cmd, input int lim);
        t_rec line [DEPTH];
        t_rec cur;
        int   idx;
        int   i;
        int   j;
        if (live_cnt < 2) begin
            return;
        end
        idx = rd_ptr;
        for (i = 0; i < live_cnt; i++) begin
            line[i] = slot_mem[idx];
            idx = ring_next(idx, lim);
        end
        for (i = 1; i < live_cnt; i++) begin
            cur = line[i];
            j = i;
            while (j > 0 && sort_key(line[j-1], cmd) > sort_key(cur, cmd)) begin
                line[j] = line[j-1];
                j--;
            end
            line[j] = cur;
        end
        idx = rd_ptr;
        for (i = 0; i < live_cnt; i++) begin
            slot_mem[idx] = line[i];
            idx = ring_next(idx, lim);
        end
    endfunction

    function automatic void predict_word(input logic [2:0] cmd, input t_rec rec);
        int   lim;
        int   newest;
        t_rsp word;
        lim = usable_slots();
        word = '0;
        case (cmd)
            CMD_PUSH: begin
                if (live_cnt >= lim) begin
                    word.status = ST_FULL;
                end else begin
                    slot_mem[wr_ptr] = rec;
                    wr_ptr = ring_next(wr_ptr, lim);
                    live_cnt++;
                end
            end
            CMD_POP: begin
                if (live_cnt == 0) begin
                    word.status = ST_EMPTY;
                end else begin
                    word.item_valid = 1'b1;
                    word.rec = slot_mem[rd_ptr];
                    rd_ptr = ring_next(rd_ptr, lim);
                    live_cnt--;
                end
            end
            CMD_SORT_CPU, CMD_SORT_PRIO, CMD_SORT_IO: begin
                sort_live(cmd, lim);
            end
            default: begin
            end
        endcase
        word.entry_count = CW'(live_cnt);
        word.is_full = (live_cnt == lim);
        word.is_empty = (live_cnt == 0);
        if (live_cnt != 0) begin
            newest = (wr_ptr == 0) ? lim - 1 : wr_ptr - 1;
            word.front_id = slot_mem[rd_ptr].proc_id;
            word.rear_id = slot_mem[newest].proc_id;
        end
        expected_words.push_back(word);
    endfunction

    function automatic void compare_field(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            word_bad = 1'b1;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            wr_ptr = 0;
            rd_ptr = 0;
            live_cnt = 0;
            cap_reg = CW'(DEPTH);
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.status = i_rsp.status;
                got.item_valid = i_rsp.item_valid;
                got.rec.proc_id = i_rsp.out_proc_id;
                got.rec.cpu_burst = i_rsp.out_cpu_burst;
                got.rec.io_burst = i_rsp.out_io_burst;
                got.rec.prio_level = i_rsp.out_prio_level;
                got.entry_count = i_rsp.entry_count;
                got.is_full = i_rsp.is_full;
                got.is_empty = i_rsp.is_empty;
                got.front_id = i_rsp.front_id;
                got.rear_id = i_rsp.rear_id;
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    word_bad = 1'b0;
                    compare_field("status", want.status, got.status);
                    compare_field("item_valid", want.item_valid, got.item_valid);
                    compare_field("out_proc_id", want.rec.proc_id, got.rec.proc_id);
                    compare_field("out_cpu_burst", want.rec.cpu_burst, got.rec.cpu_burst);
                    compare_field("out_io_burst", want.rec.io_burst, got.rec.io_burst);
                    compare_field("out_prio_level", want.rec.prio_level,
                                  got.rec.prio_level);
                    compare_field("entry_count", want.entry_count, got.entry_count);
                    compare_field("is_full", want.is_full, got.is_full);
                    compare_field("is_empty", want.is_empty, got.is_empty);
                    compare_field("front_id", want.front_id, got.front_id);
                    compare_field("rear_id", want.rear_id, got.rear_id);
                    if (word_bad) begin
                        o_fail_count++;
                    end
                end
            end
            // capacity write empties the ring, store contents kept
            if (i_cfg_we) begin
                cap_reg = i_cfg_wdata;
                wr_ptr = 0;
                rd_ptr = 0;
                live_cnt = 0;
            end
            if (i_req.valid && i_req.ready) begin
                predict_word(i_req.command, {i_req.in_proc_id, i_req.in_cpu_burst,
                                             i_req.in_io_burst, i_req.in_prio_level});
            end
        end
        o_pending = expected_words.size();
    end

endmodule

>>> sim/ring_queue_with_key_sort_tb.sv
`timescale 1ns / 1ps

module ring_queue_with_key_sort_tb import rqks_pkg::*; ();

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int         PAUSE_MAX   = 18;
    localparam int         DRAIN_LIMIT = 50000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [CW-1:0] i_cfg_wdata;
    int            fail_count;
    int            pending_words;
    bit            quiet_mode;
    int            hold_cycles;

    rqks_req_if req_ch ();
    rqks_rsp_if rsp_ch ();

    ring_queue_with_key_sort i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ring_queue_with_key_sort_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic int draw_pause();
        return quiet_mode ? 0 : int'($urandom_range(0, PAUSE_MAX));
    endfunction

    function automatic t_rec make_rec(input logic [7:0] pid, input logic [15:0] cpu,
                                      input logic [15:0] io, input logic [7:0] prio);
        return {pid, cpu, io, prio};
    endfunction

    // narrow keys half the time so that ties are common
    function automatic t_rec random_record();
        t_rec r;
        r.proc_id = 8'($urandom);
        r.cpu_burst = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        r.io_burst = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        r.prio_level = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        return r;
    endfunction

    function automatic logic [2:0] pick_command(input bit filling, input int sort_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < sort_pct) begin
            case ($urandom_range(0, 2))
                0:       return CMD_SORT_CPU;
                1:       return CMD_SORT_PRIO;
                default: return CMD_SORT_IO;
            endcase
        end
        if (r < sort_pct + 4) begin
            case ($urandom_range(0, 2))
                0:       return CMD_QUERY;
                1:       return CMD_SPARE_6;
                default: return CMD_SPARE_7;
            endcase
        end
        return ($urandom_range(0, 99) < (filling ? 75 : 25)) ? CMD_PUSH : CMD_POP;
    endfunction

    task automatic send_word(input logic [2:0] cmd, input t_rec rec);
        int pause;
        pause = draw_pause();
        if (pause > 0) begin
            req_ch.valid = 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.command = cmd;
        req_ch.in_proc_id = rec.proc_id;
        req_ch.in_cpu_burst = rec.cpu_burst;
        req_ch.in_io_burst = rec.io_burst;
        req_ch.in_prio_level = rec.prio_level;
        @(posedge i_clk);
        while (!(req_ch.valid && req_ch.ready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CW-1:0] value);
        req_ch.valid = 1'b0;
        while (pending_words != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_phase(input logic [CW-1:0] cap, input int n_items, input bit quiet);
        int eff;
        int seg;
        int sort_pct;
        write_capacity(cap);
        quiet_mode = quiet;
        eff = (cap == 0) ? 1 : (cap > CW'(DEPTH)) ? DEPTH : int'(cap);
        seg = 2 * ((eff < 24) ? eff : 24) + 6;
        sort_pct = (eff <= 16) ? 8 : 2;
        for (int i = 0; i < n_items; i++) begin
            send_word(pick_command((i % seg) < seg / 2, sort_pct), random_record());
        end
    endtask

    // receiving side
    initial begin
        int pause;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            pause = draw_pause();
            if (hold_cycles > 0) begin
                pause = hold_cycles;
                hold_cycles = 0;
            end
            if (pause > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (pause) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [CW-1:0] caps [16];
        t_rec zero_rec;
        int   waited;
        caps = '{7'd3, 7'd1, 7'd5, 7'd127, 7'd8, 7'd2, 7'd0, 7'd16,
                 7'd65, 7'd7, 7'd4, 7'd12, 7'd64, 7'd6, 7'd10, 7'd2};
        zero_rec = '0;
        quiet_mode = 1'b0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_QUERY;
        req_ch.in_proc_id = '0;
        req_ch.in_cpu_burst = '0;
        req_ch.in_io_burst = '0;
        req_ch.in_prio_level = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty queue, extremes, ties under each key, spare codes
        send_word(CMD_QUERY, zero_rec);
        send_word(CMD_POP, zero_rec);
        send_word(CMD_SORT_CPU, zero_rec);
        send_word(CMD_PUSH, make_rec(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_word(CMD_SORT_PRIO, zero_rec);
        send_word(CMD_PUSH, zero_rec);
        send_word(CMD_PUSH, make_rec(8'h5A, 16'd3, 16'd1, 8'd7));
        send_word(CMD_PUSH, make_rec(8'hA5, 16'd3, 16'd0, 8'd7));
        send_word(CMD_PUSH, make_rec(8'h3C, 16'd1, 16'd1, 8'd2));
        send_word(CMD_SORT_CPU, zero_rec);
        send_word(CMD_SORT_PRIO, zero_rec);
        send_word(CMD_SORT_IO, zero_rec);
        send_word(CMD_SPARE_6, zero_rec);
        send_word(CMD_SPARE_7, zero_rec);
        repeat (6) send_word(CMD_POP, zero_rec);

        // zero capacity behaves as one slot
        write_capacity(7'd0);
        send_word(CMD_PUSH, make_rec(8'h11, 16'd9, 16'd9, 8'd9));
        send_word(CMD_PUSH, make_rec(8'h22, 16'd8, 16'd8, 8'd8));

        // two slots, rear wraps, sort across the wrap
        write_capacity(7'd2);
        send_word(CMD_PUSH, make_rec(8'h01, 16'd5, 16'd5, 8'd5));
        send_word(CMD_PUSH, make_rec(8'h02, 16'd4, 16'd9, 8'd4));
        send_word(CMD_POP, zero_rec);
        send_word(CMD_PUSH, make_rec(8'h03, 16'd6, 16'd2, 8'd6));
        send_word(CMD_SORT_IO, zero_rec);

        for (int p = 0; p < 16; p++) begin
            run_phase(caps[p], 75, (p % 4) == 3);
        end

        // receiver holds off while the ring fills and the input backs up
        write_capacity(7'd64);
        quiet_mode = 1'b1;
        hold_cycles = 500;
        repeat (70) send_word(CMD_PUSH, random_record());
        send_word(CMD_SORT_PRIO, zero_rec);
        send_word(CMD_SORT_CPU, zero_rec);
        repeat (10) send_word(CMD_POP, zero_rec);
        send_word(CMD_SORT_IO, zero_rec);
        quiet_mode = 1'b0;
        repeat (56) send_word(CMD_POP, zero_rec);

        req_ch.valid = 1'b0;
        waited = 0;
        while (pending_words != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rqks_pkg.sv
rtl/rqks_if.sv
rtl/rqks_ram.sv
rtl/rqks_ctl.sv
rtl/rqks_dp.sv
rtl/ring_queue_with_key_sort.sv
sim/ring_queue_with_key_sort_tracker.sv
sim/ring_queue_with_key_sort_tb.sv
